@@ design/heading_error_and_drive_direction_top_defines.svh @@
// Assertion helpers shared by the block's modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef HEADING_ERROR_AND_DRIVE_DIRECTION_TOP_DEFINES_SVH
`define HEADING_ERROR_AND_DRIVE_DIRECTION_TOP_DEFINES_SVH

// Same-cycle implication
`define HEDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HEDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/heda_pkg.sv @@
`default_nettype none
package heda_pkg;

  // Parameter defaults
  localparam int COORD_WIDTH_DEF   = 12;
  localparam int CORDIC_STAGES_DEF = 16;

  // Fixed field widths
  localparam int HDG_W  = 16;  // heading / bearing, Q3.13
  localparam int TURN_W = 17;  // turn amount, Q3.13
  localparam int ZW     = 20;  // CORDIC angle accumulator, Q3.16
  localparam int DW     = 19;  // steering arithmetic width

  // Angle accumulator constants: pi/2 in Q3.16, clamp limits in Q3.13
  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [ZW:0]   ANG_MAX_Z   = 21'sd25735;
  localparam logic signed [ZW:0]   ANG_MIN_Z   = -21'sd25735;

  // Bearing limits (Q3.13)
  localparam logic signed [HDG_W-1:0] ANG_MAX  = 16'sd25735;
  localparam logic signed [HDG_W-1:0] ANG_HALF = 16'sd12868;

  // Steering constants (Q3.13)
  localparam logic signed [DW-1:0] D_HALF  = 19'sd12868;
  localparam logic signed [DW-1:0] D_PI    = 19'sd25736;
  localparam logic signed [DW-1:0] D_3HALF = 19'sd38604;
  localparam logic signed [DW-1:0] D_2PI   = 19'sd51472;
  localparam logic signed [DW-1:0] D_SATHI = 19'sd65535;
  localparam logic signed [DW-1:0] D_SATLO = -19'sd65536;

  // atan(2^-i) in Q3.16, rounded to nearest; zero from stage 17 on
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = 20'sd51472;
      1:       v = 20'sd30386;
      2:       v = 20'sd16055;
      3:       v = 20'sd8150;
      4:       v = 20'sd4091;
      5:       v = 20'sd2047;
      6:       v = 20'sd1024;
      7:       v = 20'sd512;
      8:       v = 20'sd256;
      9:       v = 20'sd128;
      10:      v = 20'sd64;
      11:      v = 20'sd32;
      12:      v = 20'sd16;
      13:      v = 20'sd8;
      14:      v = 20'sd4;
      15:      v = 20'sd2;
      16:      v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/heda_cstage.sv @@
`default_nettype none
// One vectoring iteration of the CORDIC, registered
module heda_cstage #(
  parameter int XW  = 30,
  parameter int IDX = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              v_in,
  input  wire logic signed [XW-1:0]              x_in,
  input  wire logic signed [XW-1:0]              y_in,
  input  wire logic signed [heda_pkg::ZW-1:0]    z_in,
  input  wire logic                              zero_in,
  input  wire logic signed [heda_pkg::HDG_W-1:0] hdg_in,
  output logic                                   v_r,
  output logic signed [XW-1:0]                   x_r,
  output logic signed [XW-1:0]                   y_r,
  output logic signed [heda_pkg::ZW-1:0]         z_r,
  output logic                                   zero_r,
  output logic signed [heda_pkg::HDG_W-1:0]      hdg_r
);

  localparam logic signed [heda_pkg::ZW-1:0] ATAN = heda_pkg::atan_q16(IDX);

  logic signed [XW-1:0]           xs, ys;
  logic signed [XW-1:0]           x_nxt, y_nxt;
  logic signed [heda_pkg::ZW-1:0] z_nxt;

  // Shift-and-add micro-rotation toward the x axis
  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (y_in < 0) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_in;
      hdg_r  <= hdg_in;
    end
  end

endmodule
`default_nettype wire

@@ design/heda_bearing.sv @@
`default_nettype none
// Bearing of (dx, dy): quadrant pre-rotation, CORDIC pipe, rounding to Q3.13
module heda_bearing #(
  parameter int COORD_WIDTH   = heda_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = heda_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              v_in,
  input  wire logic signed [COORD_WIDTH-1:0]     dx,
  input  wire logic signed [COORD_WIDTH-1:0]     dy,
  input  wire logic signed [heda_pkg::HDG_W-1:0] hdg_in,
  output logic                                   v_r,
  output logic signed [heda_pkg::HDG_W-1:0]      brg_r,
  output logic signed [heda_pkg::HDG_W-1:0]      hdg_r
);

  // Offset scaled by 2^16 plus two bits of CORDIC growth headroom
  localparam int XW = COORD_WIDTH + 18;
  localparam int ZW = heda_pkg::ZW;

  logic signed [XW-1:0] xi, yi;
  logic signed [XW-1:0] px_nxt, py_nxt;
  logic signed [ZW-1:0] pz_nxt;

  logic                       sv   [0:CORDIC_STAGES];
  logic signed [XW-1:0]       sx   [0:CORDIC_STAGES];
  logic signed [XW-1:0]       sy   [0:CORDIC_STAGES];
  logic signed [ZW-1:0]       sz   [0:CORDIC_STAGES];
  logic                       szro [0:CORDIC_STAGES];
  logic signed [heda_pkg::HDG_W-1:0] shdg [0:CORDIC_STAGES];

  logic signed [ZW:0]                zp, zs;
  logic signed [heda_pkg::HDG_W-1:0] brg_nxt;

  // Pre-rotation into the right half-plane
  always_comb begin
    xi = {{2{dx[COORD_WIDTH-1]}}, dx, 16'b0};
    yi = {{2{dy[COORD_WIDTH-1]}}, dy, 16'b0};
    px_nxt = xi;
    py_nxt = yi;
    pz_nxt = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        px_nxt = yi;
        py_nxt = -xi;
        pz_nxt = heda_pkg::HALF_PI_Q16;
      end else begin
        px_nxt = -yi;
        py_nxt = xi;
        pz_nxt = -heda_pkg::HALF_PI_Q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx[0]   <= px_nxt;
      sy[0]   <= py_nxt;
      sz[0]   <= pz_nxt;
      szro[0] <= (dx == 0) && (dy == 0);
      shdg[0] <= hdg_in;
    end
  end

  // Iteration stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    heda_cstage #(
      .XW  (XW),
      .IDX (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (sv[i]),
      .x_in    (sx[i]),
      .y_in    (sy[i]),
      .z_in    (sz[i]),
      .zero_in (szro[i]),
      .hdg_in  (shdg[i]),
      .v_r     (sv[i+1]),
      .x_r     (sx[i+1]),
      .y_r     (sy[i+1]),
      .z_r     (sz[i+1]),
      .zero_r  (szro[i+1]),
      .hdg_r   (shdg[i+1])
    );
  end

  // Round Q3.16 to Q3.13, clamp below pi, zero offset gives zero
  always_comb begin
    zp = {sz[CORDIC_STAGES][ZW-1], sz[CORDIC_STAGES]} + (ZW+1)'(4);
    zs = zp >>> 3;
    if (szro[CORDIC_STAGES]) begin
      brg_nxt = '0;
    end else if (zs > heda_pkg::ANG_MAX_Z) begin
      brg_nxt = heda_pkg::ANG_MAX;
    end else if (zs < heda_pkg::ANG_MIN_Z) begin
      brg_nxt = -heda_pkg::ANG_MAX;
    end else begin
      brg_nxt = zs[heda_pkg::HDG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= sv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      brg_r <= brg_nxt;
      hdg_r <= shdg[CORDIC_STAGES];
    end
  end

`include "heading_error_and_drive_direction_top_defines.svh"

  `HEDA_ASSERT_IMP(a_brg_range, v_r, (brg_r <= heda_pkg::ANG_MAX) && (brg_r >= -heda_pkg::ANG_MAX), "bearing outside clamp range")

endmodule
`default_nettype wire

@@ design/heda_steer.sv @@
`default_nettype none
// Quadrant case analysis: rotation sense, drive direction and turn amount
module heda_steer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              v_in,
  input  wire logic signed [heda_pkg::HDG_W-1:0] brg,
  input  wire logic signed [heda_pkg::HDG_W-1:0] hdg,
  output logic                                   out_valid_r,
  output logic signed [heda_pkg::TURN_W-1:0]     turn_r,
  output logic                                   acw_r,
  output logic                                   back_r
);

  localparam int DW = heda_pkg::DW;

  typedef enum logic [1:0] {QD_0, QD_1, QD_2, QD_3} quad_t;
  typedef enum logic [1:0] {OFF_ZERO, OFF_PI, OFF_NPI, OFF_2PI} off_t;

  typedef struct packed {
    logic acw;
    logic back;
    logic neg;   // offset minus difference
    logic absf;  // take magnitude afterwards
    off_t off;
  } sel_t;

  // Stage 1: heading minus bearing, quadrant of the bearing
  logic                 v1_r;
  logic signed [DW-1:0] d_r, d_nxt;
  quad_t                q_r, q_nxt;
  logic                 tpos_r, tneg_r;

  always_comb begin
    d_nxt = {{(DW-heda_pkg::HDG_W){hdg[heda_pkg::HDG_W-1]}}, hdg}
          - {{(DW-heda_pkg::HDG_W){brg[heda_pkg::HDG_W-1]}}, brg};
    if (brg >= 0 && brg < heda_pkg::ANG_HALF) begin
      q_nxt = QD_0;
    end else if (brg >= heda_pkg::ANG_HALF) begin
      q_nxt = QD_1;
    end else if (brg >= -heda_pkg::ANG_HALF) begin
      q_nxt = QD_2;
    end else begin
      q_nxt = QD_3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      q_r    <= q_nxt;
      tpos_r <= hdg > 0;
      tneg_r <= hdg < 0;
    end
  end

  // Stage 2: branch choice and the branch formula's add
  logic                 v2_r;
  sel_t                 sel;
  logic                 gt_nh, le_0, gt_0, le_h, gt_npi, le_nh, gt_n3h, lt_npi;
  logic                 gt_h, le_pi, gt_pi, le_3h, lt_0;
  logic signed [DW-1:0] offv, v_nxt, v_r;
  logic                 absf_r, acw2_r, back2_r;

  always_comb begin
    gt_nh  = d_r > -heda_pkg::D_HALF;
    le_0   = d_r <= 0;
    gt_0   = d_r > 0;
    lt_0   = d_r < 0;
    le_h   = d_r <= heda_pkg::D_HALF;
    gt_npi = d_r > -heda_pkg::D_PI;
    le_nh  = d_r <= -heda_pkg::D_HALF;
    gt_n3h = d_r > -heda_pkg::D_3HALF;
    lt_npi = d_r < -heda_pkg::D_PI;
    gt_h   = d_r > heda_pkg::D_HALF;
    le_pi  = d_r <= heda_pkg::D_PI;
    gt_pi  = d_r > heda_pkg::D_PI;
    le_3h  = d_r <= heda_pkg::D_3HALF;

    sel = '{acw: 1'b0, back: 1'b0, neg: 1'b0, absf: 1'b1, off: OFF_ZERO};
    case (q_r)
      QD_0: begin
        if (gt_nh && le_0) begin
          sel = '{1'b1, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end else if (gt_0 && le_h) begin
          sel = '{1'b0, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end else if (gt_npi && le_nh) begin
          sel = '{1'b0, 1'b1, 1'b0, 1'b1, OFF_PI};
        end else if (tpos_r) begin
          sel = '{1'b1, 1'b1, 1'b1, 1'b0, OFF_PI};
        end else begin
          sel = '{1'b1, 1'b1, 1'b0, 1'b1, OFF_PI};
        end
      end
      QD_1: begin
        if (gt_nh && le_0) begin
          sel = '{1'b1, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end else if (gt_npi && le_nh) begin
          sel = '{1'b0, 1'b1, 1'b0, 1'b1, OFF_PI};
        end else if (gt_n3h && lt_npi) begin
          sel = '{1'b1, 1'b1, 1'b0, 1'b1, OFF_PI};
        end else if (tneg_r) begin
          sel = '{1'b0, 1'b0, 1'b0, 1'b0, OFF_2PI};
        end else begin
          sel = '{1'b0, 1'b0, 1'b0, 1'b0, OFF_ZERO};
        end
      end
      QD_2: begin
        if (gt_0 && le_h) begin
          sel = '{1'b0, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end else if (gt_nh && lt_0) begin
          sel = '{1'b1, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end else if (gt_h && le_pi) begin
          sel = '{1'b1, 1'b1, 1'b0, 1'b1, OFF_NPI};
        end else if (tneg_r) begin
          sel = '{1'b0, 1'b1, 1'b0, 1'b0, OFF_PI};
        end else begin
          sel = '{1'b0, 1'b1, 1'b0, 1'b0, OFF_NPI};
        end
      end
      default: begin
        if (gt_0 && le_h) begin
          sel = '{1'b0, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end else if (gt_h && le_pi) begin
          sel = '{1'b1, 1'b1, 1'b0, 1'b1, OFF_NPI};
        end else if (gt_pi && le_3h) begin
          sel = '{1'b0, 1'b1, 1'b0, 1'b1, OFF_NPI};
        end else if (tpos_r) begin
          sel = '{1'b1, 1'b0, 1'b1, 1'b0, OFF_2PI};
        end else begin
          sel = '{1'b1, 1'b0, 1'b0, 1'b1, OFF_ZERO};
        end
      end
    endcase

    case (sel.off)
      OFF_PI:  offv = heda_pkg::D_PI;
      OFF_NPI: offv = -heda_pkg::D_PI;
      OFF_2PI: offv = heda_pkg::D_2PI;
      default: offv = '0;
    endcase

    v_nxt = sel.neg ? (offv - d_r) : (d_r + offv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r     <= v_nxt;
      absf_r  <= sel.absf;
      acw2_r  <= sel.acw;
      back2_r <= sel.back;
    end
  end

  // Stage 3: magnitude and saturation into the result register
  logic signed [DW-1:0]              m;
  logic signed [heda_pkg::TURN_W-1:0] turn_nxt;

  always_comb begin
    m = (absf_r && v_r < 0) ? -v_r : v_r;
    if (m > heda_pkg::D_SATHI) begin
      turn_nxt = heda_pkg::D_SATHI[heda_pkg::TURN_W-1:0];
    end else if (m < heda_pkg::D_SATLO) begin
      turn_nxt = heda_pkg::D_SATLO[heda_pkg::TURN_W-1:0];
    end else begin
      turn_nxt = m[heda_pkg::TURN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turn_r <= turn_nxt;
      acw_r  <= acw2_r;
      back_r <= back2_r;
    end
  end

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= v_in;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

`include "heading_error_and_drive_direction_top_defines.svh"

  `HEDA_ASSERT_NXT(a_stall_hold, !en, $stable(v1_r) && $stable(v2_r) && $stable(out_valid_r), "valid bits moved during stall")
  `HEDA_ASSERT_NXT(a_stage_adv, en && v2_r, out_valid_r, "request lost between last stages")

endmodule
`default_nettype wire

@@ design/heading_error_and_drive_direction_top.sv @@
`default_nettype none
// Heading error and drive direction. Each request carries a target offset
// (dx, dy) in grid cells and the robot heading in Q3.13 radians; the block
// finds the target bearing with a pipelined CORDIC atan2 (zero offset gives
// zero), compares it with the heading quadrant by quadrant and returns the
// turn magnitude, the rotation sense and whether to drive backward. One
// request is taken every cycle while the pipe is not held; each result
// passes one register per CORDIC iteration plus pre-rotation, rounding and
// three steering stages. When out_tready is low with a result waiting, the
// whole pipe holds and in_tready drops in the same cycle.
module heading_error_and_drive_direction_top #(
  parameter int COORD_WIDTH   = heda_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = heda_pkg::CORDIC_STAGES_DEF,
  localparam int IN_W  = ((2 * COORD_WIDTH + heda_pkg::HDG_W + 7) / 8) * 8,
  localparam int OUT_W = ((heda_pkg::TURN_W + 2 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // target_dx, target_dy, heading (low to high), zero padded
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // turn_amount, turn_anticlockwise, drive_backward (low to high), zero padded
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int CW = COORD_WIDTH;

  logic                              en;
  logic                              brg_v;
  logic signed [heda_pkg::HDG_W-1:0] brg, brg_hdg;
  logic signed [heda_pkg::TURN_W-1:0] turn;
  logic                              acw, back;

  // Pipe advances unless a result is waiting on a stalled consumer
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  heda_bearing #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_bearing (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_in   (in_tvalid),
    .dx     (in_tdata[CW-1:0]),
    .dy     (in_tdata[2*CW-1:CW]),
    .hdg_in (in_tdata[2*CW+heda_pkg::HDG_W-1:2*CW]),
    .v_r    (brg_v),
    .brg_r  (brg),
    .hdg_r  (brg_hdg)
  );

  heda_steer u_steer (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .v_in        (brg_v),
    .brg         (brg),
    .hdg         (brg_hdg),
    .out_valid_r (out_tvalid),
    .turn_r      (turn),
    .acw_r       (acw),
    .back_r      (back)
  );

  // Result packing
  assign out_tdata = {{(OUT_W - heda_pkg::TURN_W - 2){1'b0}}, back, acw, turn};

endmodule
`default_nettype wire
